// ===== src/rc4_stream_cipher_core_macros.svh =====
// ----------------------------------------------------------------------------
// RC4 cipher core assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_MACROS_SVH
`define RC4_STREAM_CIPHER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RC4_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc4 assertion failed");
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMP(label, clk, rst, ante, cons)
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 cipher core package
// Shared payload types, command codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

   localparam int KEY_BYTES_MAX_DEF = 256;
   localparam int KEY_LEN_W         = 9;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

   typedef logic [7:0] octet_type;

   // request command codes
   localparam logic [1:0] CMD_LOAD      = 2'd0;
   localparam logic [1:0] CMD_SCHEDULE  = 2'd1;
   localparam logic [1:0] CMD_TRANSFORM = 2'd2;

   // datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_IDLE      = 4'd0;
   localparam op_type OP_LOAD      = 4'd1;
   localparam op_type OP_KS_INIT   = 4'd2;
   localparam op_type OP_KS_RD     = 4'd3;
   localparam op_type OP_KS_MIX    = 4'd4;
   localparam op_type OP_KS_SWAP_A = 4'd5;
   localparam op_type OP_KS_SWAP_B = 4'd6;
   localparam op_type OP_TX_RD_I   = 4'd7;
   localparam op_type OP_TX_RD_J   = 4'd8;
   localparam op_type OP_TX_SWAP_A = 4'd9;
   localparam op_type OP_TX_SWAP_B = 4'd10;

   typedef struct packed {
      logic [1:0] command;
      octet_type  key_index;
      octet_type  key_byte;
      octet_type  data_in;
   } req_type;

   typedef struct packed {
      octet_type data_out;
   } rsp_type;

   typedef struct packed {
      logic [KEY_LEN_W-1:0] key_length;
   } csr_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ks_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/rc4_stream_if.sv =====
// ----------------------------------------------------------------------------
// RC4 stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/rc4_stream_cipher_core.sv =====
// Transform: S[i] read on acceptance, then states RD_J, SWAP_A and SWAP_B, for three
//   dependent permutation reads and the second swap write after them.
// Key load: on acceptance. Key schedule: init, then 256 RD/MIX/SWAP_A/SWAP_B steps.
// The result register frees the request side while a result waits.
// Synchronous active-high reset: identity permutation, zero indices, key length 16;
//   key store contents are undefined until loaded.
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Controller and datapath for key load, key schedule and byte transform.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_core #(
   parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rc4_stream_if.sink   req_if,
   rc4_stream_if.source rsp_if,
   rc4_stream_if.sink   csr_if
);

   rc4_pkg::ctrl_cmd_type  cmd;
   rc4_pkg::dp_status_type status;
   rc4_pkg::req_type       req_payload;
   rc4_pkg::rsp_type       rsp_payload;
   rc4_pkg::csr_type       csr_payload;

   assign req_payload    = req_if.payload;
   assign csr_payload    = csr_if.payload;
   assign rsp_if.payload = rsp_payload;

   rc4_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_command (req_payload.command),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd),
      .status      (status)
   );

   rc4_datapath #(
      .KEY_BYTES_MAX (KEY_BYTES_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_if.valid),
      .csr_ready   (csr_if.ready),
      .csr_payload (csr_payload)
   );

endmodule

`default_nettype wire

// ===== src/rc4_datapath.sv =====
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key memories, generator indices and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_datapath #(
   parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rc4_pkg::ctrl_cmd_type  cmd,
   output rc4_pkg::dp_status_type      status,
   input  wire rc4_pkg::req_type       req_payload,
   output rc4_pkg::rsp_type            rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire rc4_pkg::csr_type       csr_payload
);

   localparam int KIDX_W = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
   localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_MAX_W =
      rc4_pkg::KEY_LEN_W'(KEY_BYTES_MAX);

   // permutation store
   logic [7:0]   perm_mem [256];
   logic [255:0] valid_ff, valid_in;
   logic [7:0]   perm_rd_ff, perm_addr_ff;
   logic         perm_val_ff;
   logic         perm_re, perm_we;
   logic [7:0]   perm_ra, perm_wa, perm_wd, perm_rdata;

   // key store
   logic [7:0]        key_mem [KEY_BYTES_MAX];
   logic [7:0]        key_rd_ff;
   logic              key_re, key_we;
   logic [KIDX_W-1:0] key_ra;

   logic [7:0]        i_ff, i_in, j_ff, j_in, step_ff, step_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [rc4_pkg::KEY_LEN_W-1:0] key_length_ff, key_length_in, len_eff;

   logic [7:0] sa_ff, sa_in, sb_ff, sb_in, text_ff, text_in;
   logic [7:0] data_out_ff, data_out_in;
   logic       hit_i_ff, hit_i_in, hit_j_ff, hit_j_in;
   logic [7:0] j_new, t_addr, ks_byte;

   assign perm_rdata = perm_val_ff ? perm_rd_ff : perm_addr_ff;
   assign len_eff    = (key_length_ff == '0 || key_length_ff > KEY_MAX_W) ?
                       KEY_MAX_W : key_length_ff;
   assign ks_byte    = hit_j_ff ? sa_ff : (hit_i_ff ? sb_ff : perm_rdata);
   assign key_we     = (cmd.op == rc4_pkg::OP_LOAD) &&
                       ({1'b0, req_payload.key_index} < KEY_MAX_W);

   assign status.ks_last           = (step_ff == 8'hFF);
   assign rsp_payload.data_out     = data_out_ff;
   assign csr_ready                = 1'b1;

   always_comb begin
      i_in          = i_ff;
      j_in          = j_ff;
      step_in       = step_ff;
      kidx_in       = kidx_ff;
      valid_in      = valid_ff;
      key_length_in = csr_valid ? csr_payload.key_length : key_length_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      text_in       = text_ff;
      data_out_in   = data_out_ff;
      hit_i_in      = hit_i_ff;
      hit_j_in      = hit_j_ff;
      perm_re       = 1'b0;
      perm_ra       = '0;
      perm_we       = 1'b0;
      perm_wa       = '0;
      perm_wd       = '0;
      key_re        = 1'b0;
      key_ra        = kidx_ff;
      j_new         = '0;
      t_addr        = '0;
      case (cmd.op)
         rc4_pkg::OP_KS_INIT: begin
            valid_in = '0;
            i_in     = '0;
            j_in     = '0;
            step_in  = '0;
            kidx_in  = '0;
         end
         rc4_pkg::OP_KS_RD: begin
            perm_re = 1'b1;
            perm_ra = step_ff;
            key_re  = 1'b1;
         end
         rc4_pkg::OP_KS_MIX: begin
            sa_in   = perm_rdata;
            j_new   = 8'(j_ff + key_rd_ff + perm_rdata);
            j_in    = j_new;
            perm_re = 1'b1;
            perm_ra = j_new;
         end
         rc4_pkg::OP_KS_SWAP_A: begin
            perm_we = 1'b1;
            perm_wa = step_ff;
            perm_wd = perm_rdata;
         end
         rc4_pkg::OP_KS_SWAP_B: begin
            perm_we = 1'b1;
            perm_wa = j_ff;
            perm_wd = sa_ff;
            step_in = 8'(step_ff + 8'd1);
            if (rc4_pkg::KEY_LEN_W'(kidx_ff) + 9'd1 == len_eff) begin
               kidx_in = '0;
            end else begin
               kidx_in = KIDX_W'(kidx_ff + 1'b1);
            end
            if (status.ks_last) begin
               j_in = '0;
            end
         end
         rc4_pkg::OP_TX_RD_I: begin
            i_in    = 8'(i_ff + 8'd1);
            perm_re = 1'b1;
            perm_ra = i_in;
            text_in = req_payload.data_in;
         end
         rc4_pkg::OP_TX_RD_J: begin
            sa_in   = perm_rdata;
            j_new   = 8'(j_ff + perm_rdata);
            j_in    = j_new;
            perm_re = 1'b1;
            perm_ra = j_new;
         end
         rc4_pkg::OP_TX_SWAP_A: begin
            sb_in    = perm_rdata;
            perm_we  = 1'b1;
            perm_wa  = i_ff;
            perm_wd  = perm_rdata;
            t_addr   = 8'(sa_ff + perm_rdata);
            perm_re  = 1'b1;
            perm_ra  = t_addr;
            hit_i_in = (t_addr == i_ff);
            hit_j_in = (t_addr == j_ff);
         end
         rc4_pkg::OP_TX_SWAP_B: begin
            perm_we = 1'b1;
            perm_wa = j_ff;
            perm_wd = sa_ff;
            if (cmd.out_load) begin
               data_out_in = text_ff ^ ks_byte;
            end
         end
         default: begin
         end
      endcase
      if (perm_we) begin
         valid_in[perm_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff          <= '0;
         j_ff          <= '0;
         step_ff       <= '0;
         kidx_ff       <= '0;
         valid_ff      <= '0;
         key_length_ff <= rc4_pkg::KEY_LEN_RESET;
      end else begin
         i_ff          <= i_in;
         j_ff          <= j_in;
         step_ff       <= step_in;
         kidx_ff       <= kidx_in;
         valid_ff      <= valid_in;
         key_length_ff <= key_length_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      text_ff     <= text_in;
      data_out_ff <= data_out_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_wa] <= perm_wd;
      end
      if (perm_re) begin
         perm_rd_ff   <= perm_mem[perm_ra];
         perm_val_ff  <= valid_ff[perm_ra];
         perm_addr_ff <= perm_ra;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_payload.key_index[KIDX_W-1:0]] <= req_payload.key_byte;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_ra];
      end
   end

endmodule

`default_nettype wire

// ===== src/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences load, key schedule and transform operations of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc4_stream_cipher_core_macros.svh"

module rc4_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_command,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rc4_pkg::ctrl_cmd_type      cmd,
   input  wire rc4_pkg::dp_status_type status
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_KS_RD     = 3'd1;
   localparam logic [2:0] ST_KS_MIX    = 3'd2;
   localparam logic [2:0] ST_KS_SWAP_A = 3'd3;
   localparam logic [2:0] ST_KS_SWAP_B = 3'd4;
   localparam logic [2:0] ST_TX_RD_J   = 3'd5;
   localparam logic [2:0] ST_TX_SWAP_A = 3'd6;
   localparam logic [2:0] ST_TX_SWAP_B = 3'd7;

   logic [2:0] st_ff, st_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_acc, acc_tx;

   assign req_ready = (st_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign acc_tx    = req_acc && (req_command == rc4_pkg::CMD_TRANSFORM);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      st_in        = st_ff;
      cmd.op       = rc4_pkg::OP_IDLE;
      cmd.out_load = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_command)
                  rc4_pkg::CMD_LOAD: begin
                     cmd.op = rc4_pkg::OP_LOAD;
                  end
                  rc4_pkg::CMD_SCHEDULE: begin
                     cmd.op = rc4_pkg::OP_KS_INIT;
                     st_in  = ST_KS_RD;
                  end
                  rc4_pkg::CMD_TRANSFORM: begin
                     cmd.op = rc4_pkg::OP_TX_RD_I;
                     st_in  = ST_TX_RD_J;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_KS_RD: begin
            cmd.op = rc4_pkg::OP_KS_RD;
            st_in  = ST_KS_MIX;
         end
         ST_KS_MIX: begin
            cmd.op = rc4_pkg::OP_KS_MIX;
            st_in  = ST_KS_SWAP_A;
         end
         ST_KS_SWAP_A: begin
            cmd.op = rc4_pkg::OP_KS_SWAP_A;
            st_in  = ST_KS_SWAP_B;
         end
         ST_KS_SWAP_B: begin
            cmd.op = rc4_pkg::OP_KS_SWAP_B;
            st_in  = status.ks_last ? ST_IDLE : ST_KS_RD;
         end
         ST_TX_RD_J: begin
            cmd.op = rc4_pkg::OP_TX_RD_J;
            st_in  = ST_TX_SWAP_A;
         end
         ST_TX_SWAP_A: begin
            cmd.op = rc4_pkg::OP_TX_SWAP_A;
            st_in  = ST_TX_SWAP_B;
         end
         ST_TX_SWAP_B: begin
            // hold until the result register is free
            cmd.op = rc4_pkg::OP_TX_SWAP_B;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RC4_ASSERT_NEXT(a_tx_start, clock, reset, acc_tx, st_ff == ST_TX_RD_J)
   `RC4_ASSERT_NEXT(a_ks_done, clock, reset, st_ff == ST_KS_SWAP_B && status.ks_last, st_ff == ST_IDLE)
   `RC4_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(st_ff) == ST_TX_SWAP_B)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher core testbench
// Drives key loads, key schedules and byte transforms through the request
// channel, with random gaps on both sides and one long result back-pressure.
// A behavioral cipher model, or a directed expected value, predicts each output
// byte, and each output is checked in order. Key lengths 1 and 256, then random
// lengths from 1 to 64, are covered over several phases.
// ----------------------------------------------------------------------------

module testbench;

   localparam int          ITEM_TARGET      = 1850;
   localparam int          RESET_CYCLES     = 5;
   localparam int          SETTLE_CYCLES    = 1100;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT      = 1500000;
   localparam logic [1:0]  CMD_UNUSED       = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      rc4_pkg::octet_type key_index;
      rc4_pkg::octet_type key_byte;
      rc4_pkg::octet_type data_in;
      logic               known;
      rc4_pkg::octet_type data_out;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{rc4_pkg::CMD_TRANSFORM, 8'h00, 8'h00, 8'h00, 1'b1, 8'h02},
      '{rc4_pkg::CMD_TRANSFORM, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFA},
      '{CMD_UNUSED,             8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h00, 8'h00, 8'hFF, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h01, 8'h01, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h02, 8'h02, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h03, 8'h04, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h04, 8'h08, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h05, 8'h10, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h06, 8'h20, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h07, 8'h40, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h08, 8'h80, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h09, 8'h7F, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h0A, 8'hBF, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h0B, 8'hDF, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h0C, 8'hEF, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h0D, 8'hF7, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h0E, 8'hFB, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_LOAD,      8'h0F, 8'hFF, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_SCHEDULE,  8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00},
      '{rc4_pkg::CMD_TRANSFORM, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_TRANSFORM, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00},
      '{CMD_UNUSED,             8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_SCHEDULE,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{rc4_pkg::CMD_TRANSFORM, 8'hA5, 8'h5A, 8'h5A, 1'b0, 8'h00}
   };

   logic clock;
   logic reset;

   rc4_stream_if #(.payload_type(rc4_pkg::req_type)) req_if ();
   rc4_stream_if #(.payload_type(rc4_pkg::rsp_type)) rsp_if ();
   rc4_stream_if #(.payload_type(rc4_pkg::csr_type)) csr_if ();

   rc4_stream_cipher_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // cipher model state
   rc4_pkg::octet_type            sbox [256];
   rc4_pkg::octet_type            gen_i;
   rc4_pkg::octet_type            gen_j;
   rc4_pkg::octet_type            key_mem [256];
   logic [rc4_pkg::KEY_LEN_W-1:0] key_len;
   rc4_pkg::octet_type            pending_cipher_bytes [$];

   int          n_errors      = 0;
   int          n_checked     = 0;
   int          n_loads       = 0;
   int          n_schedules   = 0;
   int          n_ignored     = 0;
   int          n_key_lengths = 0;
   int          n_long_holds  = 0;
   int          items_sent    = 0;
   int          req_calm      = 0;
   int unsigned cycle_count   = 0;
   bit          rsp_long_hold = 1'b0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void sbox_identity();
      for (int n = 0; n < 256; n++) sbox[n] = rc4_pkg::octet_type'(n);
      gen_i = '0;
      gen_j = '0;
   endfunction

   function automatic void apply_schedule();
      int                 span;
      rc4_pkg::octet_type mix;
      rc4_pkg::octet_type held;
      span = (key_len == 0 || key_len > rc4_pkg::KEY_BYTES_MAX_DEF) ?
             rc4_pkg::KEY_BYTES_MAX_DEF : int'(key_len);
      sbox_identity();
      mix = '0;
      for (int pos = 0; pos < 256; pos++) begin
         mix = mix + key_mem[pos % span] + sbox[pos];
         held = sbox[pos];
         sbox[pos] = sbox[mix];
         sbox[mix] = held;
      end
   endfunction

   function automatic rc4_pkg::octet_type keystream_next();
      rc4_pkg::octet_type held;
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + sbox[gen_i];
      held = sbox[gen_i];
      sbox[gen_i] = sbox[gen_j];
      sbox[gen_j] = held;
      return sbox[rc4_pkg::octet_type'(sbox[gen_i] + sbox[gen_j])];
   endfunction

   function automatic rc4_pkg::req_type random_req(input logic [1:0] command);
      rc4_pkg::req_type item;
      item.command   = command;
      item.key_index = rc4_pkg::octet_type'($urandom);
      item.key_byte  = rc4_pkg::octet_type'($urandom);
      item.data_in   = rc4_pkg::octet_type'($urandom);
      return item;
   endfunction

   task automatic send_item(input rc4_pkg::req_type item, input bit known,
                            input rc4_pkg::octet_type typed_out);
      int                 gap;
      rc4_pkg::octet_type ks;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (item.command)
         rc4_pkg::CMD_LOAD: begin
            key_mem[item.key_index] = item.key_byte;
            n_loads++;
         end
         rc4_pkg::CMD_SCHEDULE: begin
            apply_schedule();
            n_schedules++;
         end
         rc4_pkg::CMD_TRANSFORM: begin
            ks = keystream_next();
            pending_cipher_bytes.push_back(known ? typed_out : (item.data_in ^ ks));
         end
         default: n_ignored++;
      endcase
      if (item.command != CMD_UNUSED) items_sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_cipher_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [rc4_pkg::KEY_LEN_W-1:0] len);
      csr_if.payload <= rc4_pkg::csr_type'(len);
      csr_if.valid   <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      key_len = len;
      n_key_lengths++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_cipher_bytes.size() == 0) begin
            $error("data_out: expected none, actual %02h", rsp_if.payload.data_out);
            n_errors++;
         end else begin
            if (rsp_if.payload.data_out !== pending_cipher_bytes[0]) begin
               $error("data_out: expected %02h, actual %02h",
                      pending_cipher_bytes[0], rsp_if.payload.data_out);
               n_errors++;
            end
            void'(pending_cipher_bytes.pop_front());
            n_checked++;
         end
      end
   end

   initial begin : rsp_sink
      int on_len;
      int off_len;
      int calm;
      calm = 0;
      forever begin
         on_len = $urandom_range(1, 12);
         rsp_if.ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            off_len = LONG_HOLD_CYCLES;
            n_long_holds++;
         end else begin
            off_len = pick_gap(calm);
         end
         if (off_len > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      rc4_pkg::req_type              item;
      directed_row_type              row;
      int                            phase;
      int                            sessions;
      int                            run_len;
      int                            roll;
      int                            len_min;
      int                            len_max;
      logic [rc4_pkg::KEY_LEN_W-1:0] len;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      sbox_identity();
      key_len = rc4_pkg::KEY_LEN_RESET;
      len_min = int'(rc4_pkg::KEY_LEN_RESET);
      len_max = int'(rc4_pkg::KEY_LEN_RESET);

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         row = DIRECTED[n];
         item.command   = row.command;
         item.key_index = row.key_index;
         item.key_byte  = row.key_byte;
         item.data_in   = row.data_in;
         send_item(item, row.known, row.data_out);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0:       len = 9'd1;
            1:       len = 9'd256;
            default: len = ($urandom_range(0, 9) < 7) ?
                           rc4_pkg::KEY_LEN_W'($urandom_range(1, 16)) :
                           rc4_pkg::KEY_LEN_W'($urandom_range(17, 64));
         endcase
         if (int'(len) < len_min) len_min = int'(len);
         if (int'(len) > len_max) len_max = int'(len);
         wait_idle();
         write_key_length(len);

         // stale keystream after a length change
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4))
               send_item(random_req(rc4_pkg::CMD_TRANSFORM), 1'b0, '0);
         end

         sessions = (len > 64) ? 1 : $urandom_range(1, 3);
         for (int s = 0; s < sessions; s++) begin
            if (s == 0 || $urandom_range(0, 1) == 1) begin
               for (int k = 0; k < int'(len); k++) begin
                  if ($urandom_range(0, 19) == 0) send_item(random_req(CMD_UNUSED), 1'b0, '0);
                  item = random_req(rc4_pkg::CMD_LOAD);
                  item.key_index = rc4_pkg::octet_type'(k);
                  send_item(item, 1'b0, '0);
               end
            end
            if ($urandom_range(0, 4) == 0) send_item(random_req(rc4_pkg::CMD_LOAD), 1'b0, '0);
            send_item(random_req(rc4_pkg::CMD_SCHEDULE), 1'b0, '0);

            run_len = $urandom_range(4, 40);
            if (phase == 2 && s == 0) begin
               run_len = 80;
               rsp_long_hold = 1'b1;
            end
            for (int t = 0; t < run_len; t++) begin
               roll = $urandom_range(0, 99);
               if (roll < 90)      send_item(random_req(rc4_pkg::CMD_TRANSFORM), 1'b0, '0);
               else if (roll < 94) send_item(random_req(CMD_UNUSED), 1'b0, '0);
               else if (roll < 97) send_item(random_req(rc4_pkg::CMD_LOAD), 1'b0, '0);
               else                send_item(random_req(rc4_pkg::CMD_SCHEDULE), 1'b0, '0);
            end
         end
         phase++;
      end

      wait_idle();
      $display("summary: %0d key loads, %0d schedules, %0d bytes checked, %0d ignored commands",
               n_loads, n_schedules, n_checked, n_ignored);
      $display("summary: %0d key length writes from %0d to %0d, %0d long result hold-offs",
               n_key_lengths, len_min, len_max, n_long_holds);
      if (n_errors == 0 && pending_cipher_bytes.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/rc4_pkg.sv
src/rc4_stream_if.sv
src/rc4_datapath.sv
src/rc4_ctrl.sv
src/rc4_stream_cipher_core.sv
dv/testbench.sv
